>>> rtl/core/tbavg_pkg.sv
// ----------------------------------------------------------------------------
// tbavg_pkg
// Shared constants and types for the three-axis block average.
// ----------------------------------------------------------------------------
package tbavg_pkg;

    localparam int MAX_SAMPLES = 32;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // one closed run, handed from the accumulator to the divider
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic [CNT_W-1:0]        count;
        logic                    dropped;
    } run_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

endpackage

>>> rtl/core/three_axis_block_average.sv
// ----------------------------------------------------------------------------
// three_axis_block_average
// Averages runs of signed three-axis samples, one result per run.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample word per cycle: tdata = {z, y, x} (x lowest),
//   tlast closes the run. Up to MAX_SAMPLES words of a run are summed, later
//   words are dropped and reported through m_axis_tuser.
//   m_axis carries one word per run: tdata = {avg_z, avg_y, avg_x}, each the
//   sum divided by the count, truncated toward zero.
//   Input words are taken one per cycle while the two-entry run queue has
//   room. Each closed run is divided in a shared serial divider, one quotient
//   bit per cycle over SUM_W bits for each axis in turn. The next queued run
//   is taken only once the current result has moved to the output register.
//   A stalled receiver holds the result in the output register; the divider
//   then waits, the queue fills and s_axis_tready falls.
//   Reset clears the accumulators, the queue and the output valid.
// ----------------------------------------------------------------------------
module three_axis_block_average
    import tbavg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // x_sample, y_sample, z_sample
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // avg_x, avg_y, avg_z
    output logic        m_axis_tuser    // too_many
);

    logic    in_accept;
    logic    run_push;
    run_t    run_in;
    run_t    run_out;
    q_ctrl_t q_ctrl;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic signed [SAMPLE_W-1:0] avg_x, avg_y, avg_z;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    tbavg_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .x_sample    (s_axis_tdata[15:0]),
        .y_sample    (s_axis_tdata[31:16]),
        .z_sample    (s_axis_tdata[47:32]),
        .last_sample (s_axis_tlast),
        .run_push    (run_push),
        .run_data    (run_in)
    );

    assign q_ctrl.push  = run_push;
    assign q_ctrl.pop   = q_pop;

    tbavg_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_in (q_ctrl),
        .wr_data (run_in),
        .rd_data (run_out),
        .full    (q_full),
        .empty   (q_empty)
    );

    tbavg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (run_out),
        .q_pop    (q_pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .avg_x    (avg_x),
        .avg_y    (avg_y),
        .avg_z    (avg_z),
        .too_many (m_axis_tuser)
    );

    assign m_axis_tdata = {avg_z, avg_y, avg_x};

endmodule

>>> rtl/core/tbavg_front.sv
// ----------------------------------------------------------------------------
// tbavg_front
// Accepts sample words, accumulates the three axes and closes a run on tlast.
// ----------------------------------------------------------------------------
module tbavg_front
    import tbavg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_accept,
    input  logic signed [SAMPLE_W-1:0] x_sample,
    input  logic signed [SAMPLE_W-1:0] y_sample,
    input  logic signed [SAMPLE_W-1:0] z_sample,
    input  logic                       last_sample,
    output logic                       run_push,
    output run_t                       run_data
);

    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic signed [SUM_W-1:0] sum_z_reg, sum_z_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    dropped_reg, dropped_next;
    logic                    in_room;
    run_t                    upd;

    assign in_room = count_reg < CNT_W'(MAX_SAMPLES);

    always_comb begin
        upd.sum_x   = sum_x_reg;
        upd.sum_y   = sum_y_reg;
        upd.sum_z   = sum_z_reg;
        upd.count   = count_reg;
        upd.dropped = dropped_reg;
        if (in_room) begin
            upd.sum_x = sum_x_reg + SUM_W'(x_sample);
            upd.sum_y = sum_y_reg + SUM_W'(y_sample);
            upd.sum_z = sum_z_reg + SUM_W'(z_sample);
            upd.count = count_reg + CNT_W'(1);
        end else begin
            upd.dropped = 1'b1;
        end
    end

    always_comb begin
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        sum_z_next   = sum_z_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (in_accept) begin
            if (last_sample) begin
                sum_x_next   = '0;
                sum_y_next   = '0;
                sum_z_next   = '0;
                count_next   = '0;
                dropped_next = 1'b0;
            end else begin
                sum_x_next   = upd.sum_x;
                sum_y_next   = upd.sum_y;
                sum_z_next   = upd.sum_z;
                count_next   = upd.count;
                dropped_next = upd.dropped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_z_reg   <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            sum_z_reg   <= sum_z_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign run_push = in_accept && last_sample;
    assign run_data = upd;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above maximum");

endmodule

>>> rtl/core/tbavg_queue.sv
// ----------------------------------------------------------------------------
// tbavg_queue
// Short queue of closed runs between the accumulator and the divider.
// ----------------------------------------------------------------------------
module tbavg_queue
    import tbavg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  q_ctrl_t ctrl_in,
    input  run_t    wr_data,
    output run_t    rd_data,
    output logic    full,
    output logic    empty
);

    run_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign full    = fill_reg == QCNT_W'(QDEPTH);
    assign empty   = fill_reg == '0;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (ctrl_in.push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (ctrl_in.pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (ctrl_in.push && !ctrl_in.pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (ctrl_in.pop && !ctrl_in.push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_in.push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_in.pop |-> !empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/core/tbavg_back.sv
// ----------------------------------------------------------------------------
// tbavg_back
// Serial restoring divider shared by the three axes, plus the output register.
// ----------------------------------------------------------------------------
module tbavg_back
    import tbavg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  run_t                       q_data,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] avg_x,
    output logic signed [SAMPLE_W-1:0] avg_y,
    output logic signed [SAMPLE_W-1:0] avg_z,
    output logic                       too_many
);

    localparam int BIT_W = $clog2(SUM_W);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    run_t                        run_reg;
    logic [1:0]                  axis_reg;
    logic [BIT_W-1:0]            bit_reg;
    logic [SUM_W-1:0]            dvd_reg;
    logic [CNT_W-1:0]            rem_reg;
    logic                        neg_reg;
    logic signed [SAMPLE_W-1:0]  res_x_reg, res_y_reg, res_z_reg;
    logic                        m_valid_reg;
    logic signed [SAMPLE_W-1:0]  avg_x_reg, avg_y_reg, avg_z_reg;
    logic                        too_many_reg;

    logic signed [SUM_W-1:0]     sel_sum;
    logic [CNT_W:0]              trial;
    logic                        fits;
    logic [SUM_W-1:0]            quot;
    logic [SUM_W-1:0]            signed_q;
    logic                        div_last;
    logic                        out_free;

    always_comb begin
        case (axis_reg)
            AXIS_X:  sel_sum = run_reg.sum_x;
            AXIS_Y:  sel_sum = run_reg.sum_y;
            default: sel_sum = run_reg.sum_z;
        endcase
    end

    assign trial    = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits     = trial >= {1'b0, run_reg.count};
    assign quot     = {dvd_reg[SUM_W-2:0], fits};
    assign signed_q = neg_reg ? -quot : quot;
    assign div_last = bit_reg == BIT_W'(SUM_W - 1);
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!q_empty) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_DIV;
            ST_DIV: begin
                if (div_last) begin
                    state_next = (axis_reg == AXIS_Z) ? ST_DONE : ST_SETUP;
                end
            end
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= AXIS_X;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                axis_reg <= AXIS_X;
            end else if (state_reg == ST_DIV && div_last && axis_reg != AXIS_Z) begin
                axis_reg <= axis_reg + 2'd1;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            run_reg <= q_data;
        end
        if (state_reg == ST_SETUP) begin
            neg_reg <= sel_sum[SUM_W-1];
            dvd_reg <= sel_sum[SUM_W-1] ? -sel_sum : sel_sum;
            rem_reg <= '0;
            bit_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            dvd_reg <= quot;
            rem_reg <= fits ? CNT_W'(trial - {1'b0, run_reg.count}) : trial[CNT_W-1:0];
            bit_reg <= bit_reg + BIT_W'(1);
            if (div_last) begin
                case (axis_reg)
                    AXIS_X:  res_x_reg <= signed_q[SAMPLE_W-1:0];
                    AXIS_Y:  res_y_reg <= signed_q[SAMPLE_W-1:0];
                    default: res_z_reg <= signed_q[SAMPLE_W-1:0];
                endcase
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            avg_x_reg    <= res_x_reg;
            avg_y_reg    <= res_y_reg;
            avg_z_reg    <= res_z_reg;
            too_many_reg <= run_reg.dropped;
        end
    end

    assign m_valid  = m_valid_reg;
    assign avg_x    = avg_x_reg;
    assign avg_y    = avg_y_reg;
    assign avg_z    = avg_z_reg;
    assign too_many = too_many_reg;

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> axis_reg == AXIS_X || axis_reg == AXIS_Y
                                || axis_reg == AXIS_Z)
        else $error("axis select out of range");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && div_last && axis_reg == AXIS_Z |=> state_reg == ST_DONE)
        else $error("divider did not finish run");

endmodule

>>> dv/run_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_average_checker
// Watches both stream channels of the block average and checks every result.
// Each accepted sample word updates a private copy of the run sums. A word
// marked last queues the expected averages and dropped flag. Each accepted
// result word is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module run_average_checker
    import tbavg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // x_sample, y_sample, z_sample
    input  logic        s_axis_tlast,   // last_sample
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // avg_x, avg_y, avg_z
    input  logic        m_axis_tuser,   // too_many
    output int          fail_count,
    output int          pending,
    output int          runs_checked,
    output int          dropped_runs
);

    typedef struct {
        logic signed [SAMPLE_W-1:0] avg_x;
        logic signed [SAMPLE_W-1:0] avg_y;
        logic signed [SAMPLE_W-1:0] avg_z;
        logic                       too_many;
    } avg_word_t;

    logic signed [SUM_W-1:0] run_sum_x = '0;
    logic signed [SUM_W-1:0] run_sum_y = '0;
    logic signed [SUM_W-1:0] run_sum_z = '0;
    logic [CNT_W-1:0]        run_len   = '0;
    logic                    run_dropped = 1'b0;

    avg_word_t expected_avgs[$];
    int        fails   = 0;
    int        checked = 0;
    int        dropped = 0;

    // signed divide truncates toward zero, as the block must
    function automatic logic signed [SAMPLE_W-1:0] mean_of(
        input logic signed [SUM_W-1:0] total,
        input logic [CNT_W-1:0]        n
    );
        logic signed [SUM_W-1:0] q;
        q = total / $signed({{(SUM_W-CNT_W){1'b0}}, n});
        return q[SAMPLE_W-1:0];
    endfunction

    task automatic take_sample(input logic [47:0] word, input logic last);
        logic signed [SAMPLE_W-1:0] sx;
        logic signed [SAMPLE_W-1:0] sy;
        logic signed [SAMPLE_W-1:0] sz;
        avg_word_t                  want;
        sx = word[15:0];
        sy = word[31:16];
        sz = word[47:32];
        if (run_len < MAX_SAMPLES) begin
            run_sum_x = run_sum_x + sx;
            run_sum_y = run_sum_y + sy;
            run_sum_z = run_sum_z + sz;
            run_len   = run_len + 1'b1;
        end else begin
            run_dropped = 1'b1;
        end
        if (last) begin
            want.avg_x    = mean_of(run_sum_x, run_len);
            want.avg_y    = mean_of(run_sum_y, run_len);
            want.avg_z    = mean_of(run_sum_z, run_len);
            want.too_many = run_dropped;
            expected_avgs.push_back(want);
            run_sum_x   = '0;
            run_sum_y   = '0;
            run_sum_z   = '0;
            run_len     = '0;
            run_dropped = 1'b0;
        end
    endtask

    task automatic check_result(input logic [47:0] word, input logic flag);
        avg_word_t                  want;
        logic signed [SAMPLE_W-1:0] got_x;
        logic signed [SAMPLE_W-1:0] got_y;
        logic signed [SAMPLE_W-1:0] got_z;
        got_x = word[15:0];
        got_y = word[31:16];
        got_z = word[47:32];
        if (expected_avgs.size() == 0) begin
            $error("unexpected result word: avg_x %0d avg_y %0d avg_z %0d too_many %0b",
                   got_x, got_y, got_z, flag);
            fails++;
        end else begin
            want = expected_avgs.pop_front();
            checked++;
            if (want.too_many) dropped++;
            if (got_x !== want.avg_x) begin
                $error("avg_x mismatch: expected %0d, got %0d", want.avg_x, got_x);
                fails++;
            end
            if (got_y !== want.avg_y) begin
                $error("avg_y mismatch: expected %0d, got %0d", want.avg_y, got_y);
                fails++;
            end
            if (got_z !== want.avg_z) begin
                $error("avg_z mismatch: expected %0d, got %0d", want.avg_z, got_z);
                fails++;
            end
            if (flag !== want.too_many) begin
                $error("too_many mismatch: expected %0b, got %0b", want.too_many, flag);
                fails++;
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        if (!aresetn) begin
            run_sum_x   = '0;
            run_sum_y   = '0;
            run_sum_z   = '0;
            run_len     = '0;
            run_dropped = 1'b0;
            expected_avgs.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_sample(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata, m_axis_tuser);
            end
        end
        fail_count   <= fails;
        pending      <= expected_avgs.size();
        runs_checked <= checked;
        dropped_runs <= dropped;
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the three-axis block average.
// A short directed set hits the sample extremes and truncation toward zero,
// then random runs of mixed length (full and overlong ones included) follow,
// with random idle bursts on both channels. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import tbavg_pkg::*;

    localparam int RANDOM_WORDS = 850;
    localparam int CALM_WORDS   = 80;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int pending;
    int runs_checked;
    int dropped_runs;

    int cycles      = 0;
    int words_sent  = 0;
    int runs_sent   = 0;
    int idle_pct    = 0;
    bit calm        = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    three_axis_block_average DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    run_average_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .runs_checked  (runs_checked),
        .dropped_runs  (dropped_runs)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver back-pressure: short stalls, with long stall-free stretches
    initial begin : receiver
        int gap;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 99) < 3) begin
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 99) < 12) begin
                gap = $urandom_range(1, 10);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic put_word(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SAMPLE_W-1:0] y,
        input logic signed [SAMPLE_W-1:0] z,
        input logic                       last
    );
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
        if (last) runs_sent++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int extreme_pct);
        if ($urandom_range(0, 99) < extreme_pct) begin
            case ($urandom_range(0, 4))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return -16'sd1;
                3:       return 16'sd1;
                default: return 16'sd0;
            endcase
        end
        return SAMPLE_W'($urandom());
    endfunction

    task automatic send_run(input int len);
        int extreme_pct;
        extreme_pct = ($urandom_range(0, 3) == 0) ? 80 : 10;
        for (int i = 0; i < len; i++) begin
            put_word(pick_sample(extreme_pct), pick_sample(extreme_pct),
                     pick_sample(extreme_pct), i == len - 1);
        end
    endtask

    function automatic int pick_run_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(1, 4);
        if (r < 75) return $urandom_range(5, 12);
        if (r < 90) return $urandom_range(13, MAX_SAMPLES - 1);
        if (r < 96) return MAX_SAMPLES + $urandom_range(0, 1);
        return $urandom_range(MAX_SAMPLES + 2, MAX_SAMPLES + 12);
    endfunction

    // the checker's count is registered and may not yet show the last accepted word
    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int start_words;
        bit paused;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-word runs at the field extremes and alternating bit patterns
        put_word(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1);
        put_word(16'sh8000, 16'sh7FFF, -16'sd1, 1'b1);
        put_word(16'sh5555, 16'shAAAA, 16'sh5555, 1'b1);
        // averages that do not divide evenly go toward zero, not down
        put_word(16'sd1, -16'sd1, 16'sd0, 1'b0);
        put_word(16'sd0, 16'sd0, 16'sd1, 1'b1);
        put_word(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
        put_word(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1);
        put_word(-16'sd5, 16'sd7, 16'sh8000, 1'b0);
        put_word(16'sd0, 16'sd0, 16'sh8000, 1'b0);
        put_word(-16'sd1, 16'sd1, -16'sd32767, 1'b1);
        for (int i = 0; i < 4; i++) begin
            put_word(16'sh8000, 16'sh8000, 16'sh7FFF, i == 3);
        end
        put_word(-16'sd7, 16'sd7, 16'sd5, 1'b0);
        put_word(16'sd0, 16'sd0, 16'sd0, 1'b0);
        put_word(16'sd0, 16'sd0, 16'sd0, 1'b1);

        s_axis_tvalid <= 1'b0;
        wait_drained();

        // full, one-over and well-over runs first, then mixed lengths
        start_words = words_sent;
        paused      = 1'b0;
        idle_pct    = 20;
        send_run(MAX_SAMPLES);
        send_run(MAX_SAMPLES + 1);
        send_run(MAX_SAMPLES + 10);
        while (words_sent - start_words < RANDOM_WORDS) begin
            if (runs_sent % 12 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (!paused && words_sent - start_words > RANDOM_WORDS / 2) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                wait_drained();
                paused = 1'b1;
            end
            if (words_sent - start_words > RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
            send_run(pick_run_len());
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d sample words in %0d runs sent; %0d averages checked, %0d of them overlong",
                 words_sent, runs_sent, runs_checked, dropped_runs);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
